// File: rtl/cbas_pkg.sv
// Shared types, codes and constants of the CPU bus access sequencer.
package cbas_pkg;

  // Default configuration.
  localparam int ADDR_BITS_DEF = 32;
  localparam int OUT_DEPTH_DEF = 4;

  // Request function codes.
  typedef logic [3:0] func_t;
  localparam func_t FN_READ      = 4'd0;
  localparam func_t FN_WRITE     = 4'd1;
  localparam func_t FN_PUSH      = 4'd2;
  localparam func_t FN_POP       = 4'd3;
  localparam func_t FN_PREFETCH  = 4'd4;
  localparam func_t FN_TAKE_PF   = 4'd5;
  localparam func_t FN_EXTENSION = 4'd6;
  localparam func_t FN_REPLY     = 4'd7;
  localparam func_t FN_LOAD_PC   = 4'd8;
  localparam func_t FN_LOAD_SP   = 4'd9;

  // Access size codes.
  typedef logic [1:0] size_t;
  localparam size_t SZ_BYTE = 2'd0;
  localparam size_t SZ_WORD = 2'd1;
  localparam size_t SZ_LONG = 2'd2;
  localparam size_t SZ_NONE = 2'd3;

  // Result kind codes.
  typedef logic [1:0] kind_t;
  localparam kind_t K_READ  = 2'd0;
  localparam kind_t K_WRITE = 2'd1;
  localparam kind_t K_DATA  = 2'd2;

  // Pending operation codes.
  typedef logic [1:0] pend_t;
  localparam pend_t PK_NONE     = 2'd0;
  localparam pend_t PK_READ     = 2'd1;
  localparam pend_t PK_PREFETCH = 2'd2;
  localparam pend_t PK_EXT      = 2'd3;

  // One request beat.
  typedef struct packed {
    func_t       func;
    size_t       size;
    logic [31:0] address;
    logic [31:0] data;
    logic [15:0] reply_data;
  } req_t;

  // One result beat.
  typedef struct packed {
    kind_t       kind;
    logic        upper_select;
    logic        lower_select;
    logic [31:0] bus_address;
    logic [15:0] bus_write_data;
    logic [31:0] result_value;
    logic        last;
  } res_t;

endpackage

// File: rtl/cbas_ifs.sv
// Valid/ready channel interfaces for requests and results.
interface cbas_req_if;
  import cbas_pkg::*;
  logic        valid;
  logic        ready;
  func_t       func;
  size_t       size;
  logic [31:0] address;
  logic [31:0] data;
  logic [15:0] reply_data;

  modport source (output valid, func, size, address, data, reply_data, input ready);
  modport sink   (input valid, func, size, address, data, reply_data, output ready);
endinterface

interface cbas_res_if;
  import cbas_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic        upper_select;
  logic        lower_select;
  logic [31:0] bus_address;
  logic [15:0] bus_write_data;
  logic [31:0] result_value;
  logic        last;

  modport source (output valid, kind, upper_select, lower_select, bus_address,
                  bus_write_data, result_value, last, input ready);
  modport sink   (input valid, kind, upper_select, lower_select, bus_address,
                  bus_write_data, result_value, last, output ready);
endinterface

// File: rtl/cbas_core.sv
// Sequencer state and single-pass decode of one request into up to two results.
module cbas_core #(
  parameter int ADDR_BITS = cbas_pkg::ADDR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  cbas_pkg::req_t req,
  output logic [1:0]     res_cnt,
  output cbas_pkg::res_t res0,
  output cbas_pkg::res_t res1
);
  import cbas_pkg::*;

  localparam logic [32:0] AMASK_W = (33'd1 << ADDR_BITS) - 33'd1;
  localparam logic [31:0] AMASK   = AMASK_W[31:0];

  logic [31:0] pc_r, pc_nxt;
  logic [31:0] sp_r, sp_nxt;
  logic [15:0] iw_r, iw_nxt;
  logic [15:0] pf_r, pf_nxt;
  pend_t       pk_r, pk_nxt;
  size_t       psize_r, psize_nxt;
  logic        phase_r, phase_nxt;
  logic [31:0] paddr_r, paddr_nxt;
  logic [15:0] high_r, high_nxt;

  logic [31:0] nbytes;
  logic [31:0] sp_dec;
  logic [31:0] acc_addr;
  logic        done;
  logic [31:0] done_val;

  // Word-aligned bus address limited to the address bus width.
  function automatic logic [31:0] bus_addr(input logic [31:0] a);
    return (a & ~32'd1) & AMASK;
  endfunction

  function automatic res_t rd_cycle(input logic us, input logic ls, input logic [31:0] a);
    res_t r;
    r              = '0;
    r.kind         = K_READ;
    r.upper_select = us;
    r.lower_select = ls;
    r.bus_address  = bus_addr(a);
    r.last         = 1'b1;
    return r;
  endfunction

  function automatic res_t wr_cycle(input logic us, input logic ls, input logic [31:0] a,
                                    input logic [15:0] wd, input logic lst);
    res_t r;
    r                = '0;
    r.kind           = K_WRITE;
    r.upper_select   = us;
    r.lower_select   = ls;
    r.bus_address    = bus_addr(a);
    r.bus_write_data = wd;
    r.last           = lst;
    return r;
  endfunction

  // Access size in bytes for stack pointer adjustment.
  always_comb begin
    unique case (req.size)
      SZ_BYTE: nbytes = 32'd1;
      SZ_WORD: nbytes = 32'd2;
      default: nbytes = 32'd4;
    endcase
  end

  assign sp_dec = sp_r - nbytes;

  // Write and push share the lane steering; push uses the decremented stack pointer.
  assign acc_addr = (req.func == FN_PUSH) ? sp_dec : req.address;

  // Decode of the current request against the sequencer state.
  always_comb begin
    pc_nxt    = pc_r;
    sp_nxt    = sp_r;
    iw_nxt    = iw_r;
    pf_nxt    = pf_r;
    pk_nxt    = pk_r;
    psize_nxt = psize_r;
    phase_nxt = phase_r;
    paddr_nxt = paddr_r;
    high_nxt  = high_r;
    res_cnt   = 2'd0;
    res0      = '0;
    res1      = '0;
    done      = 1'b0;
    done_val  = '0;

    if (req.func == FN_REPLY) begin
      // Bus reply completes or advances the pending operation.
      unique case (pk_r)
        PK_READ: begin
          if (psize_r == SZ_BYTE) begin
            done     = 1'b1;
            done_val = {24'd0, paddr_r[0] ? req.reply_data[7:0] : req.reply_data[15:8]};
          end else if (psize_r == SZ_WORD) begin
            done     = 1'b1;
            done_val = {16'd0, req.reply_data};
          end else if (!phase_r) begin
            high_nxt  = req.reply_data;
            phase_nxt = 1'b1;
            res_cnt   = 2'd1;
            res0      = rd_cycle(1'b1, 1'b1, paddr_r + 32'd2);
          end else begin
            done     = 1'b1;
            done_val = {high_r, req.reply_data};
          end
        end
        PK_PREFETCH: begin
          pf_nxt   = req.reply_data;
          done     = 1'b1;
          done_val = {16'd0, iw_r};
        end
        PK_EXT: begin
          pf_nxt = req.reply_data;
          if (psize_r == SZ_BYTE) begin
            done     = 1'b1;
            done_val = {24'd0, iw_r[7:0]};
          end else if (psize_r == SZ_WORD) begin
            done     = 1'b1;
            done_val = {16'd0, iw_r};
          end else if (!phase_r) begin
            // Second extension fetch: the reply word becomes the instruction word.
            high_nxt  = iw_r;
            phase_nxt = 1'b1;
            iw_nxt    = req.reply_data;
            pc_nxt    = pc_r + 32'd2;
            res_cnt   = 2'd1;
            res0      = rd_cycle(1'b1, 1'b1, pc_r);
          end else begin
            done     = 1'b1;
            done_val = {high_r, iw_r};
          end
        end
        default: begin
        end
      endcase
      if (done) begin
        pk_nxt            = PK_NONE;
        phase_nxt         = 1'b0;
        res_cnt           = 2'd1;
        res0.kind         = K_DATA;
        res0.result_value = done_val;
        res0.last         = 1'b1;
      end
    end else if (pk_r == PK_NONE) begin
      unique case (req.func) inside
        FN_READ, FN_POP: begin
          if (req.size != SZ_NONE) begin
            pk_nxt    = PK_READ;
            psize_nxt = req.size;
            phase_nxt = 1'b0;
            paddr_nxt = (req.func == FN_POP) ? sp_r : req.address;
            if (req.func == FN_POP) begin
              sp_nxt = sp_r + nbytes;
            end
            res_cnt = 2'd1;
            res0    = rd_cycle((req.size != SZ_BYTE) || !paddr_nxt[0],
                               (req.size != SZ_BYTE) || paddr_nxt[0], paddr_nxt);
          end
        end
        FN_WRITE, FN_PUSH: begin
          if (req.size != SZ_NONE) begin
            if (req.func == FN_PUSH) begin
              sp_nxt = sp_dec;
            end
            if (req.size == SZ_BYTE) begin
              res_cnt = 2'd1;
              res0    = wr_cycle(!acc_addr[0], acc_addr[0], acc_addr,
                                 {req.data[7:0], req.data[7:0]}, 1'b1);
            end else if (req.size == SZ_WORD) begin
              res_cnt = 2'd1;
              res0    = wr_cycle(1'b1, 1'b1, acc_addr, req.data[15:0], 1'b1);
            end else if (req.func == FN_PUSH) begin
              // Push long writes the low word first.
              res_cnt = 2'd2;
              res0    = wr_cycle(1'b1, 1'b1, acc_addr + 32'd2, req.data[15:0], 1'b0);
              res1    = wr_cycle(1'b1, 1'b1, acc_addr, req.data[31:16], 1'b1);
            end else begin
              res_cnt = 2'd2;
              res0    = wr_cycle(1'b1, 1'b1, acc_addr, req.data[31:16], 1'b0);
              res1    = wr_cycle(1'b1, 1'b1, acc_addr + 32'd2, req.data[15:0], 1'b1);
            end
          end
        end
        FN_PREFETCH, FN_EXTENSION: begin
          if (req.func == FN_PREFETCH || req.size != SZ_NONE) begin
            pk_nxt    = (req.func == FN_PREFETCH) ? PK_PREFETCH : PK_EXT;
            psize_nxt = (req.func == FN_PREFETCH) ? SZ_WORD : req.size;
            phase_nxt = 1'b0;
            iw_nxt    = pf_r;
            pc_nxt    = pc_r + 32'd2;
            res_cnt   = 2'd1;
            res0      = rd_cycle(1'b1, 1'b1, pc_r);
          end
        end
        FN_TAKE_PF: begin
          iw_nxt            = pf_r;
          pf_nxt            = 16'h0000;
          pc_nxt            = pc_r + 32'd2;
          res_cnt           = 2'd1;
          res0.kind         = K_DATA;
          res0.result_value = {16'd0, pf_r};
          res0.last         = 1'b1;
        end
        FN_LOAD_PC: pc_nxt = req.address;
        FN_LOAD_SP: sp_nxt = req.address;
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      sp_r    <= '0;
      iw_r    <= '0;
      pf_r    <= '0;
      pk_r    <= PK_NONE;
      psize_r <= SZ_BYTE;
      phase_r <= 1'b0;
      paddr_r <= '0;
      high_r  <= '0;
    end else if (go) begin
      pc_r    <= pc_nxt;
      sp_r    <= sp_nxt;
      iw_r    <= iw_nxt;
      pf_r    <= pf_nxt;
      pk_r    <= pk_nxt;
      psize_r <= psize_nxt;
      phase_r <= phase_nxt;
      paddr_r <= paddr_nxt;
      high_r  <= high_nxt;
    end
  end

endmodule

// File: rtl/cbas_outq.sv
// Result queue that takes up to two beats per cycle and delivers one per cycle while q_ready is high.
module cbas_outq #(
  parameter int DEPTH = cbas_pkg::OUT_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_cnt,
  input  cbas_pkg::res_t push0,
  input  cbas_pkg::res_t push1,
  output logic           room2,
  output logic           q_valid,
  input  logic           q_ready,
  output cbas_pkg::res_t q_data
);
  import cbas_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  res_t          ent_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, wp_inc;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop     = q_valid && q_ready;
  assign q_valid = (cnt_r != '0);
  assign q_data  = ent_r[rp_r];
  assign room2   = (cnt_r <= CW'(DEPTH - 2));
  assign wp_inc  = ptr_inc(wp_r);

  // Pointer and level update.
  always_comb begin
    wp_nxt = wp_r;
    if (push_cnt == 2'd1) begin
      wp_nxt = wp_inc;
    end else if (push_cnt == 2'd2) begin
      wp_nxt = ptr_inc(wp_inc);
    end
    rp_nxt  = pop ? ptr_inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      ent_r[wp_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      ent_r[wp_inc] <= push1;
    end
  end

endmodule

// File: rtl/cpu_bus_access_sequencer.sv
// Top level of the CPU bus access sequencer: input register, decode core, result queue.
//
//   channel  | dir | handshake     | beat
//   in_bus   | in  | valid / ready | func, size, address, data, reply_data
//   out_bus  | out | valid / ready | kind, strobes, bus_address, write data, value, last
//
// A request is taken into the input register and decoded once the queue has room;
// its one or two result beats go through the result queue to out_bus. One request
// per cycle is sustained while the queue has room for two beats; a long write or
// push puts two beats into the four-entry result queue, and the output port passes
// one beat a cycle while out_bus is ready. A held request waits in the input register
// while the queue has room for fewer than two beats. Reset (rst_n low at a clock edge)
// clears PC, SP, the prefetch pair, the pending operation and the queue.
module cpu_bus_access_sequencer #(
  parameter int ADDR_BITS = cbas_pkg::ADDR_BITS_DEF,
  parameter int OUT_DEPTH = cbas_pkg::OUT_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cbas_req_if.sink  in_bus,
  cbas_res_if.source out_bus
);
  import cbas_pkg::*;

  logic       in_v_r;
  req_t       in_r;
  logic       proc;
  logic       room2;
  logic [1:0] res_cnt;
  res_t       res0, res1;
  res_t       q_data;
  logic [1:0] push_cnt;

  // Input register advances when it is empty or when the queue can take a worst-case pair of beats.
  assign proc         = in_v_r && room2;
  assign in_bus.ready = !in_v_r || proc;
  assign push_cnt     = proc ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_r.func       <= in_bus.func;
      in_r.size       <= in_bus.size;
      in_r.address    <= in_bus.address;
      in_r.data       <= in_bus.data;
      in_r.reply_data <= in_bus.reply_data;
    end
  end

  cbas_core #(
    .ADDR_BITS(ADDR_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (proc),
    .req    (in_r),
    .res_cnt(res_cnt),
    .res0   (res0),
    .res1   (res1)
  );

  cbas_outq #(
    .DEPTH(OUT_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_cnt(push_cnt),
    .push0   (res0),
    .push1   (res1),
    .room2   (room2),
    .q_valid (out_bus.valid),
    .q_ready (out_bus.ready),
    .q_data  (q_data)
  );

  // Result port.
  assign out_bus.kind           = q_data.kind;
  assign out_bus.upper_select   = q_data.upper_select;
  assign out_bus.lower_select   = q_data.lower_select;
  assign out_bus.bus_address    = q_data.bus_address;
  assign out_bus.bus_write_data = q_data.bus_write_data;
  assign out_bus.result_value   = q_data.result_value;
  assign out_bus.last           = q_data.last;

  // A two-beat request marks only its second beat as last.
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && res_cnt == 2'd2) |-> (!res0.last && res1.last))
    else $error("two-beat request has wrong last marking");

  // A held request stays in the input register until it is decoded.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !proc) |=> in_v_r)
    else $error("held request lost");

  // Bus cycles always carry a word-aligned address.
  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.kind != K_DATA) |-> !out_bus.bus_address[0])
    else $error("unaligned bus address");

endmodule
